// ===== src/reservoir_fill_and_pump_sequencer_unit_macros.svh =====
// Assertion macros for the reservoir fill and pump sequencer.
`ifndef RESERVOIR_FILL_AND_PUMP_SEQUENCER_UNIT_MACROS_SVH
`define RESERVOIR_FILL_AND_PUMP_SEQUENCER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RFPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RFPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RFPS_ASSERT(lbl, prop, msg)
`define RFPS_ASSERT_IMP(lbl, ante, cons, msg)
`define RFPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/rfps_pkg.sv =====
// Shared constants for the reservoir fill and pump sequencer.
package rfps_pkg;

  localparam int NOW_W    = 32;
  localparam int ECHO_W   = 20;
  localparam int WEIGHT_W = 18;
  localparam int DIST_W   = 15;
  localparam int MS_W     = 32;
  localparam int IDX_W    = 3;
  localparam int DATA_W   = 32;
  localparam int MIX_W    = 3;

  // floor(echo*17/1000) = floor(floor(echo*17/8) / 125), reciprocal exact for 22-bit values
  localparam int ECHO17_W   = 25;
  localparam int SCALED_W   = 22;
  localparam int RECIP_W    = 23;
  localparam int PROD_W     = SCALED_W + RECIP_W;
  localparam int RECIP_SH   = 29;
  localparam logic [RECIP_W-1:0] DIST_RECIP = 23'd4294968;

  localparam logic [IDX_W-1:0] REG_WATER_LIMIT = 3'd0;
  localparam logic [IDX_W-1:0] REG_SOL_A_LIMIT = 3'd1;
  localparam logic [IDX_W-1:0] REG_SOL_B_LIMIT = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOW_LEVEL   = 3'd3;
  localparam logic [IDX_W-1:0] REG_REFILL      = 3'd4;
  localparam logic [IDX_W-1:0] REG_PUMP_ON     = 3'd5;
  localparam logic [IDX_W-1:0] REG_PUMP_OFF    = 3'd6;

  localparam logic signed [WEIGHT_W-1:0] WATER_LIMIT_RST = 18'sd10000;
  localparam logic signed [WEIGHT_W-1:0] SOL_A_LIMIT_RST = 18'sd10010;
  localparam logic signed [WEIGHT_W-1:0] SOL_B_LIMIT_RST = 18'sd10020;
  localparam logic [DIST_W-1:0] LOW_LEVEL_RST = 15'd10;
  localparam logic [DIST_W-1:0] REFILL_RST    = 15'd25;
  localparam logic [MS_W-1:0]   PUMP_ON_RST   = 32'd180000;
  localparam logic [MS_W-1:0]   PUMP_OFF_RST  = 32'd720000;

  localparam logic [MIX_W-1:0] MIX_OFF   = 3'b000;
  localparam logic [MIX_W-1:0] MIX_WATER = 3'b001;
  localparam logic [MIX_W-1:0] MIX_SOL_A = 3'b010;
  localparam logic [MIX_W-1:0] MIX_SOL_B = 3'b100;

  localparam logic MODE_FILL = 1'b0;
  localparam logic MODE_PUMP = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = 15'd17825;

endpackage

// ===== src/rfps_dist.sv =====
// Echo width to distance conversion, floor(echo_us * 17 / 1000).
module rfps_dist (
  input  logic [rfps_pkg::ECHO_W-1:0] echo,
  output logic [rfps_pkg::DIST_W-1:0] dist_cm
);

  logic [rfps_pkg::ECHO17_W-1:0] echo17;
  logic [rfps_pkg::SCALED_W-1:0] scaled;
  logic [rfps_pkg::PROD_W-1:0]   prod;

  always_comb begin
    echo17  = {1'b0, echo, 4'b0000} + rfps_pkg::ECHO17_W'(echo);
    scaled  = echo17[rfps_pkg::ECHO17_W-1:3];
    prod    = rfps_pkg::PROD_W'(scaled) * rfps_pkg::PROD_W'(rfps_pkg::DIST_RECIP);
    dist_cm = prod[rfps_pkg::RECIP_SH +: rfps_pkg::DIST_W];
  end

endmodule

// ===== src/reservoir_fill_and_pump_sequencer_unit.sv =====
// Reservoir fill and pump sequencer: top level with control pipeline and registers.
// One control pass can be accepted every clock while in_stall is low. A pass moves through
// an input register, a distance stage (one constant reciprocal multiply) and the control
// stage, where mode, mixing relays and the pump interval timer update together and load
// the result register. The input stalls only while all three registers hold a pass and
// the result is stalled. Configuration writes are always ready and take effect at once;
// write them only while idle. Indexes above the last register are ignored. TIME_BITS
// sets the timer width; now_ms is reduced to or zero-extended to that width.
`include "reservoir_fill_and_pump_sequencer_unit_macros.svh"
module reservoir_fill_and_pump_sequencer_unit #(
  parameter int TIME_BITS = 32
) (
  input  logic clk,
  input  logic rst,

  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rfps_pkg::IDX_W-1:0]            cfg_index,
  input  logic [rfps_pkg::DATA_W-1:0]           cfg_data,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [rfps_pkg::NOW_W-1:0]            now_ms,
  input  logic [rfps_pkg::ECHO_W-1:0]           echo_us,
  input  logic signed [rfps_pkg::WEIGHT_W-1:0]  weight_g,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  mix_water_on,
  output logic                                  mix_sol_a_on,
  output logic                                  mix_sol_b_on,
  output logic                                  pump_on,
  output logic                                  pump_mode,
  output logic [rfps_pkg::DIST_W-1:0]           distance_cm
);

  localparam int CmpW = (TIME_BITS > rfps_pkg::MS_W) ? TIME_BITS : rfps_pkg::MS_W;

  // configuration registers
  logic signed [rfps_pkg::WEIGHT_W-1:0] water_limit_g;
  logic signed [rfps_pkg::WEIGHT_W-1:0] sol_a_limit_g;
  logic signed [rfps_pkg::WEIGHT_W-1:0] sol_b_limit_g;
  logic [rfps_pkg::DIST_W-1:0]          low_level_cm;
  logic [rfps_pkg::DIST_W-1:0]          refill_level_cm;
  logic [rfps_pkg::MS_W-1:0]            pump_on_ms;
  logic [rfps_pkg::MS_W-1:0]            pump_off_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      water_limit_g   <= rfps_pkg::WATER_LIMIT_RST;
      sol_a_limit_g   <= rfps_pkg::SOL_A_LIMIT_RST;
      sol_b_limit_g   <= rfps_pkg::SOL_B_LIMIT_RST;
      low_level_cm    <= rfps_pkg::LOW_LEVEL_RST;
      refill_level_cm <= rfps_pkg::REFILL_RST;
      pump_on_ms      <= rfps_pkg::PUMP_ON_RST;
      pump_off_ms     <= rfps_pkg::PUMP_OFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rfps_pkg::REG_WATER_LIMIT: water_limit_g   <= cfg_data[rfps_pkg::WEIGHT_W-1:0];
        rfps_pkg::REG_SOL_A_LIMIT: sol_a_limit_g   <= cfg_data[rfps_pkg::WEIGHT_W-1:0];
        rfps_pkg::REG_SOL_B_LIMIT: sol_b_limit_g   <= cfg_data[rfps_pkg::WEIGHT_W-1:0];
        rfps_pkg::REG_LOW_LEVEL:   low_level_cm    <= cfg_data[rfps_pkg::DIST_W-1:0];
        rfps_pkg::REG_REFILL:      refill_level_cm <= cfg_data[rfps_pkg::DIST_W-1:0];
        rfps_pkg::REG_PUMP_ON:     pump_on_ms      <= cfg_data[rfps_pkg::MS_W-1:0];
        rfps_pkg::REG_PUMP_OFF:    pump_off_ms     <= cfg_data[rfps_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid, s2_valid;
  logic out_ready, s2_ready, s1_ready, s2_adv;

  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign s2_adv    = s2_valid && out_ready;
  assign in_stall  = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  // stage 1: input register
  logic [rfps_pkg::NOW_W-1:0]           s1_now;
  logic [rfps_pkg::ECHO_W-1:0]          s1_echo;
  logic signed [rfps_pkg::WEIGHT_W-1:0] s1_weight;

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_now    <= now_ms;
      s1_echo   <= echo_us;
      s1_weight <= weight_g;
    end
  end

  // stage 2: distance
  logic [rfps_pkg::DIST_W-1:0]          s1_dist;
  logic [rfps_pkg::NOW_W-1:0]           s2_now;
  logic [rfps_pkg::DIST_W-1:0]          s2_dist;
  logic signed [rfps_pkg::WEIGHT_W-1:0] s2_weight;

  rfps_dist u_dist (
    .echo    (s1_echo),
    .dist_cm (s1_dist)
  );

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_now    <= s1_now;
      s2_dist   <= s1_dist;
      s2_weight <= s1_weight;
    end
  end

  // control state
  logic                         mode, mode_next;
  logic                         pump_phase, pump_phase_next;
  logic [TIME_BITS-1:0]         phase_start, phase_start_next;
  logic                         pump_drive, pump_drive_next;
  logic [rfps_pkg::MIX_W-1:0]   mix_drive, mix_drive_next;

  logic [TIME_BITS-1:0]         now_t;
  logic [TIME_BITS-1:0]         elapsed;
  logic                         on_done, off_done;
  logic [rfps_pkg::MIX_W-1:0]   mix_sel;
  logic                         at_refill, at_low;

  always_comb begin
    now_t     = TIME_BITS'(s2_now);
    elapsed   = now_t - phase_start;
    on_done   = CmpW'(elapsed) >= CmpW'(pump_on_ms);
    off_done  = CmpW'(elapsed) >= CmpW'(pump_off_ms);
    at_refill = s2_dist >= refill_level_cm;
    at_low    = s2_dist <= low_level_cm;

    // later band tests override earlier ones
    mix_sel = rfps_pkg::MIX_OFF;
    if (s2_weight <= water_limit_g) begin
      mix_sel = rfps_pkg::MIX_WATER;
    end
    if (s2_weight > water_limit_g && s2_weight < sol_a_limit_g) begin
      mix_sel = rfps_pkg::MIX_SOL_A;
    end
    if (s2_weight > sol_a_limit_g && s2_weight < sol_b_limit_g) begin
      mix_sel = rfps_pkg::MIX_SOL_B;
    end
    if (s2_weight >= sol_b_limit_g) begin
      mix_sel = rfps_pkg::MIX_OFF;
    end

    mode_next        = mode;
    pump_phase_next  = pump_phase;
    phase_start_next = phase_start;
    pump_drive_next  = pump_drive;
    mix_drive_next   = mix_drive;

    if (mode == rfps_pkg::MODE_FILL) begin
      pump_drive_next = 1'b0;
      if (s2_weight <= sol_b_limit_g && at_refill) begin
        mix_drive_next = mix_sel;
      end
      if (at_low) begin
        mode_next = rfps_pkg::MODE_PUMP;
      end
    end
    // pump section also runs on the pass that entered pump mode
    if (mode_next == rfps_pkg::MODE_PUMP) begin
      mix_drive_next = rfps_pkg::MIX_OFF;
      if (pump_phase && on_done) begin
        pump_phase_next  = 1'b0;
        phase_start_next = now_t;
        pump_drive_next  = 1'b0;
      end else if (!pump_phase && off_done) begin
        pump_phase_next  = 1'b1;
        phase_start_next = now_t;
        pump_drive_next  = 1'b1;
      end
      if (at_refill) begin
        mode_next = rfps_pkg::MODE_FILL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= rfps_pkg::MODE_FILL;
      pump_phase  <= 1'b0;
      phase_start <= '0;
      pump_drive  <= 1'b0;
      mix_drive   <= rfps_pkg::MIX_OFF;
    end else if (s2_adv) begin
      mode        <= mode_next;
      pump_phase  <= pump_phase_next;
      phase_start <= phase_start_next;
      pump_drive  <= pump_drive_next;
      mix_drive   <= mix_drive_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      mix_water_on <= mix_drive_next[0];
      mix_sol_a_on <= mix_drive_next[1];
      mix_sol_b_on <= mix_drive_next[2];
      pump_on      <= pump_drive_next;
      pump_mode    <= mode_next;
      distance_cm  <= s2_dist;
    end
  end

  `RFPS_ASSERT_IMP(a_mix_onehot, out_valid,
                   $onehot0({mix_sol_b_on, mix_sol_a_on, mix_water_on}),
                   "more than one mixing relay on")
  `RFPS_ASSERT_IMP(a_pump_no_mix, out_valid && pump_mode,
                   !mix_water_on && !mix_sol_a_on && !mix_sol_b_on,
                   "mixing relay on in pump mode")
  `RFPS_ASSERT_NEXT(a_state_hold, !s2_adv,
                    $stable({mode, pump_phase, phase_start, pump_drive, mix_drive}),
                    "control state changed without a pass")
  `RFPS_ASSERT_IMP(a_empty_accepts, !out_valid, !in_stall,
                   "input stalled with empty result register")
  `RFPS_ASSERT_IMP(a_dist_range, out_valid, distance_cm <= rfps_pkg::DIST_MAX,
                   "distance out of range")

endmodule

// ===== test/reservoir_fill_and_pump_sequencer_unit_checker.sv =====
// Checker for the reservoir fill and pump sequencer: tracks registers, predicts each pass, compares.
module reservoir_fill_and_pump_sequencer_unit_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [rfps_pkg::IDX_W-1:0]           cfg_index,
  input  logic [rfps_pkg::DATA_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [rfps_pkg::NOW_W-1:0]           now_ms,
  input  logic [rfps_pkg::ECHO_W-1:0]          echo_us,
  input  logic signed [rfps_pkg::WEIGHT_W-1:0] weight_g,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic                                 mix_water_on,
  input  logic                                 mix_sol_a_on,
  input  logic                                 mix_sol_b_on,
  input  logic                                 pump_on,
  input  logic                                 pump_mode,
  input  logic [rfps_pkg::DIST_W-1:0]          distance_cm,
  output int                                   mismatches,
  output int                                   pending
);

  typedef struct packed {
    logic                        water;
    logic                        sol_a;
    logic                        sol_b;
    logic                        pump;
    logic                        mode;
    logic [rfps_pkg::DIST_W-1:0] dist_cm;
  } relay_word_t;

  logic signed [rfps_pkg::WEIGHT_W-1:0] water_lim, sol_a_lim, sol_b_lim;
  logic [rfps_pkg::DIST_W-1:0]          low_lvl, refill_lvl;
  logic [rfps_pkg::MS_W-1:0]            on_ms, off_ms;

  logic                         mode_q;
  logic                         phase_on;
  logic [rfps_pkg::NOW_W-1:0]   phase_t0;
  logic                         pump_q;
  logic [rfps_pkg::MIX_W-1:0]   mix_q;

  relay_word_t relay_q[$];
  int          fail_cnt = 0;

  // band tests run in order; a later hit overrides an earlier one
  function automatic logic [rfps_pkg::MIX_W-1:0] band_of(
      logic signed [rfps_pkg::WEIGHT_W-1:0] w);
    logic [rfps_pkg::MIX_W-1:0] sel;
    sel = rfps_pkg::MIX_OFF;
    if (w <= water_lim) sel = rfps_pkg::MIX_WATER;
    if (w > water_lim && w < sol_a_lim) sel = rfps_pkg::MIX_SOL_A;
    if (w > sol_a_lim && w < sol_b_lim) sel = rfps_pkg::MIX_SOL_B;
    if (w >= sol_b_lim) sel = rfps_pkg::MIX_OFF;
    return sel;
  endfunction

  task automatic run_pass(input logic [rfps_pkg::NOW_W-1:0] now,
                          input logic [rfps_pkg::ECHO_W-1:0] echo,
                          input logic signed [rfps_pkg::WEIGHT_W-1:0] w,
                          output relay_word_t r);
    int unsigned                 scaled;
    logic [rfps_pkg::DIST_W-1:0] d;
    logic [rfps_pkg::NOW_W-1:0]  elapsed;
    scaled = 32'(echo) * 32'd17;
    d = rfps_pkg::DIST_W'(scaled / 32'd1000);
    if (mode_q == rfps_pkg::MODE_FILL) begin
      pump_q = 1'b0;
      if (w <= sol_b_lim && d >= refill_lvl) mix_q = band_of(w);
      if (d <= low_lvl) mode_q = rfps_pkg::MODE_PUMP;
    end
    if (mode_q == rfps_pkg::MODE_PUMP) begin
      mix_q = rfps_pkg::MIX_OFF;
      elapsed = now - phase_t0;
      if (phase_on && elapsed >= on_ms) begin
        phase_on = 1'b0;
        phase_t0 = now;
        pump_q = 1'b0;
      end else if (!phase_on && elapsed >= off_ms) begin
        phase_on = 1'b1;
        phase_t0 = now;
        pump_q = 1'b1;
      end
      if (d >= refill_lvl) mode_q = rfps_pkg::MODE_FILL;
    end
    r.water   = |(mix_q & rfps_pkg::MIX_WATER);
    r.sol_a   = |(mix_q & rfps_pkg::MIX_SOL_A);
    r.sol_b   = |(mix_q & rfps_pkg::MIX_SOL_B);
    r.pump    = pump_q;
    r.mode    = mode_q;
    r.dist_cm = d;
  endtask

  task automatic note_fail(string what, int want, int seen);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, seen);
  endtask

  always @(posedge clk) begin
    relay_word_t want;
    relay_word_t got;
    if (rst) begin
      water_lim  = rfps_pkg::WATER_LIMIT_RST;
      sol_a_lim  = rfps_pkg::SOL_A_LIMIT_RST;
      sol_b_lim  = rfps_pkg::SOL_B_LIMIT_RST;
      low_lvl    = rfps_pkg::LOW_LEVEL_RST;
      refill_lvl = rfps_pkg::REFILL_RST;
      on_ms      = rfps_pkg::PUMP_ON_RST;
      off_ms     = rfps_pkg::PUMP_OFF_RST;
      mode_q     = rfps_pkg::MODE_FILL;
      phase_on   = 1'b0;
      phase_t0   = '0;
      pump_q     = 1'b0;
      mix_q      = rfps_pkg::MIX_OFF;
      relay_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rfps_pkg::REG_WATER_LIMIT: water_lim  = cfg_data[rfps_pkg::WEIGHT_W-1:0];
          rfps_pkg::REG_SOL_A_LIMIT: sol_a_lim  = cfg_data[rfps_pkg::WEIGHT_W-1:0];
          rfps_pkg::REG_SOL_B_LIMIT: sol_b_lim  = cfg_data[rfps_pkg::WEIGHT_W-1:0];
          rfps_pkg::REG_LOW_LEVEL:   low_lvl    = cfg_data[rfps_pkg::DIST_W-1:0];
          rfps_pkg::REG_REFILL:      refill_lvl = cfg_data[rfps_pkg::DIST_W-1:0];
          rfps_pkg::REG_PUMP_ON:     on_ms      = cfg_data[rfps_pkg::MS_W-1:0];
          rfps_pkg::REG_PUMP_OFF:    off_ms     = cfg_data[rfps_pkg::MS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        run_pass(now_ms, echo_us, weight_g, want);
        relay_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got.water   = mix_water_on;
        got.sol_a   = mix_sol_a_on;
        got.sol_b   = mix_sol_b_on;
        got.pump    = pump_on;
        got.mode    = pump_mode;
        got.dist_cm = distance_cm;
        if (relay_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("result transfer with no pass outstanding");
        end else begin
          want = relay_q.pop_front();
          if (got.water !== want.water) note_fail("mix_water_on", want.water, got.water);
          if (got.sol_a !== want.sol_a) note_fail("mix_sol_a_on", want.sol_a, got.sol_a);
          if (got.sol_b !== want.sol_b) note_fail("mix_sol_b_on", want.sol_b, got.sol_b);
          if (got.pump !== want.pump) note_fail("pump_on", want.pump, got.pump);
          if (got.mode !== want.mode) note_fail("pump_mode", want.mode, got.mode);
          if (got.dist_cm !== want.dist_cm)
            note_fail("distance_cm", want.dist_cm, got.dist_cm);
        end
      end
    end
    pending    <= relay_q.size();
    mismatches <= fail_cnt;
  end

endmodule

// ===== test/tb_reservoir_fill_and_pump_sequencer_unit.sv =====
// Testbench top for the reservoir fill and pump sequencer: stimulus, idling and verdict.
module tb_reservoir_fill_and_pump_sequencer_unit;

  localparam logic [rfps_pkg::IDX_W-1:0] REG_NONE = 3'd7;

  logic                                 clk;
  logic                                 rst;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [rfps_pkg::IDX_W-1:0]           cfg_index;
  logic [rfps_pkg::DATA_W-1:0]          cfg_data;
  logic                                 in_valid;
  logic                                 in_stall;
  logic [rfps_pkg::NOW_W-1:0]           now_ms;
  logic [rfps_pkg::ECHO_W-1:0]          echo_us;
  logic signed [rfps_pkg::WEIGHT_W-1:0] weight_g;
  logic                                 out_valid;
  logic                                 out_stall;
  logic                                 mix_water_on;
  logic                                 mix_sol_a_on;
  logic                                 mix_sol_b_on;
  logic                                 pump_on;
  logic                                 pump_mode;
  logic [rfps_pkg::DIST_W-1:0]          distance_cm;
  int                                   mismatches;
  int                                   pending;

  bit                         calm;
  int                         squeeze_ask;
  int                         lim_w, lim_a, lim_b, lvl_low, lvl_refill;
  logic [rfps_pkg::MS_W-1:0]  t_on, t_off;
  logic [rfps_pkg::NOW_W-1:0] clock_ms;

  reservoir_fill_and_pump_sequencer_unit DUT (.*);

  reservoir_fill_and_pump_sequencer_unit_checker relay_check (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // smallest echo width that lands on the given distance
  function automatic logic [rfps_pkg::ECHO_W-1:0] echo_for_cm(int cm);
    int e;
    if (cm < 0) cm = 0;
    e = (cm * 1000 + 16) / 17;
    if (e > 20'hFFFFF) e = 20'hFFFFF;
    return rfps_pkg::ECHO_W'(e);
  endfunction

  task automatic send_pass(logic [rfps_pkg::NOW_W-1:0] now,
                           logic [rfps_pkg::ECHO_W-1:0] echo, int w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms   <= now;
    echo_us  <= echo;
    weight_g <= rfps_pkg::WEIGHT_W'(w);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [rfps_pkg::IDX_W-1:0] idx,
                           logic [rfps_pkg::DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_setting(int wl, int al, int bl, int lo, int rf,
                              logic [rfps_pkg::MS_W-1:0] on,
                              logic [rfps_pkg::MS_W-1:0] off);
    write_reg(rfps_pkg::REG_WATER_LIMIT, {14'($urandom), 18'(wl)});
    write_reg(rfps_pkg::REG_SOL_A_LIMIT, {14'($urandom), 18'(al)});
    write_reg(rfps_pkg::REG_SOL_B_LIMIT, {14'($urandom), 18'(bl)});
    write_reg(rfps_pkg::REG_LOW_LEVEL, {17'($urandom), 15'(lo)});
    write_reg(rfps_pkg::REG_REFILL, {17'($urandom), 15'(rf)});
    write_reg(rfps_pkg::REG_PUMP_ON, on);
    write_reg(rfps_pkg::REG_PUMP_OFF, off);
    write_reg(REG_NONE, $urandom);
    cfg_valid  <= 1'b0;
    lim_w      = wl;
    lim_a      = al;
    lim_b      = bl;
    lvl_low    = lo;
    lvl_refill = rf;
    t_on       = on;
    t_off      = off;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  // mostly plausible passes aimed at the thresholds, some pure noise
  task automatic random_passes(int count);
    logic [rfps_pkg::MS_W-1:0]  big;
    logic [rfps_pkg::NOW_W-1:0] step;
    int                         span, pick, cm, wt;
    repeat (count) begin
      if ($urandom_range(0, 99) < 12) begin
        send_pass($urandom, rfps_pkg::ECHO_W'($urandom),
                  int'($urandom_range(0, 262143)) - 131072);
      end else begin
        big  = (t_on > t_off) ? t_on : t_off;
        span = (big > 2000000) ? 2000000 : ((big == 0) ? 16 : int'(big));
        pick = $urandom_range(0, 9);
        if (pick < 5) step = $urandom_range(0, 40);
        else if (pick < 8) step = $urandom_range(0, span);
        else if (pick == 8) step = $urandom_range(0, 1) ? t_on : t_off;
        else step = $urandom;
        clock_ms += step;

        pick = $urandom_range(0, 9);
        if (pick < 6)
          cm = ($urandom_range(0, 1) ? lvl_low : lvl_refill) + int'($urandom_range(0, 2)) - 1;
        else if (pick < 9) cm = $urandom_range(0, lvl_refill + 20);
        else cm = $urandom_range(0, 17825);

        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          case ($urandom_range(0, 2))
            0: wt = lim_w;
            1: wt = lim_a;
            default: wt = lim_b;
          endcase
          wt += int'($urandom_range(0, 4)) - 2;
        end else if (pick < 9) begin
          wt = lim_w + int'($urandom_range(0, 1200)) - 600;
        end else begin
          wt = int'($urandom_range(0, 262143)) - 131072;
        end
        send_pass(clock_ms, echo_for_cm(cm), wt);
      end
    end
  endtask

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int hold, run, served;
    hold = 0;
    run = 0;
    served = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (served != squeeze_ask) begin
        served = squeeze_ask;
        hold = 80;
        run = 0;
      end else if (calm) begin
        hold = 0;
        run = 0;
      end else if (hold == 0 && run == 0) begin
        hold = idle_len();
        if (hold == 0) run = $urandom_range(1, 8);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if (run > 0) run--;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    now_ms      = '0;
    echo_us     = '0;
    weight_g    = '0;
    calm        = 1'b0;
    squeeze_ask = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // power-on settings: band edges, echo extremes, pump timer and wrap
    send_pass(32'd0, echo_for_cm(30), -131072);
    send_pass(32'd1, echo_for_cm(30), 10000);
    send_pass(32'd2, echo_for_cm(30), 10001);
    send_pass(32'd3, echo_for_cm(30), 10010);
    send_pass(32'd4, echo_for_cm(30), 10011);
    send_pass(32'd5, echo_for_cm(30), 10019);
    send_pass(32'd6, echo_for_cm(30), 10020);
    send_pass(32'd7, echo_for_cm(30), 10015);
    send_pass(32'd8, echo_for_cm(30), 131071);
    send_pass(32'd9, 20'hFFFFF, 10005);
    send_pass(32'd10, echo_for_cm(20), 5000);
    send_pass(32'd100, 20'h00000, -1);
    send_pass(32'd720000, echo_for_cm(15), 0);
    send_pass(32'd800000, echo_for_cm(15), 0);
    send_pass(32'd900000, echo_for_cm(15), 0);
    send_pass(32'hFFFF_0000, echo_for_cm(15), 0);
    send_pass(32'h0001_0000, echo_for_cm(15), 0);
    send_pass(32'h0002_C000, echo_for_cm(15), 0);
    send_pass(32'h0002_C001, echo_for_cm(25), 10000);
    send_pass(32'h0002_C002, echo_for_cm(25), 10000);
    send_pass(32'h0002_C003, echo_for_cm(10), 10005);
    send_pass(32'h0002_C004, 20'h55555, -43691);
    drain();
    clock_ms = 32'h0002_C010;

    calm = 1'b1;
    load_setting(200, 400, 600, 50, 120, 32'd40, 32'd90);
    random_passes(220);
    drain();
    calm = 1'b0;

    load_setting(-131072, 0, 131071, 0, 17000, 32'd0, 32'hFFFF_FFFF);
    squeeze_ask++;
    random_passes(220);
    drain();

    load_setting(500, -300, 200, 30, 20, 32'hFFFF_FFFF, 32'd0);
    random_passes(220);
    drain();

    load_setting(131071, -131072, -131072, 32767, 0, 32'd1, 32'd1);
    random_passes(220);
    drain();

    load_setting(10000, 10010, 10020, 10, 25, 32'd3000, 32'd5000);
    squeeze_ask++;
    random_passes(220);
    drain();

    repeat (2) begin
      load_setting(int'($urandom_range(0, 2000)) - 1000, int'($urandom_range(0, 2000)) - 1000,
                   int'($urandom_range(0, 2000)) - 1000, $urandom_range(0, 300),
                   $urandom_range(0, 300), $urandom_range(0, 5000), $urandom_range(0, 5000));
      random_passes(220);
      drain();
    end

    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
